// ----- rtl/wha_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wha_pkg;

  localparam int NumBins = 1024;
  localparam int SlotW = 10;
  localparam int HeightW = 48;
  localparam int DivW = 36;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SHIFT = 2'd2,
    REQ_SLOT  = 2'd3
  } req_t;

  localparam logic [0:0] REG_ANCHOR = 1'b0;
  localparam logic [0:0] REG_BIN_SIZE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_RDW,
    ST_UPD,
    ST_SW_RD,
    ST_SW_RDW,
    ST_SW_WR,
    ST_OUT,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic upd;
    logic sw_rd;
    logic sw_wr;
    logic sw_inc;
    logic clr_wr;
    logic clr_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sw_last;
    logic clr_last;
    logic is_oor;
  } sts_t;

  function automatic logic signed [HeightW-1:0] sat_add(
      input logic signed [HeightW-1:0] h, input logic signed [32:0] d);
    logic signed [HeightW:0] s;
    s = {h[HeightW-1], h} + {{(HeightW-32){d[32]}}, d};
    if (s[HeightW] != s[HeightW-1])
      return s[HeightW] ? {1'b1, {(HeightW-1){1'b0}}} : {1'b0, {(HeightW-1){1'b1}}};
    return s[HeightW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/wha_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/wha_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wha_ctrl import wha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic [1:0] in_type,
  input  wire logic out_fire,
  input  wire sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);
  state_t state, state_next;
  logic [1:0] op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      op <= 2'd0;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    case (state)
      ST_CLR: if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          op_next = in_type;
          case (req_t'(in_type))
            REQ_SHIFT: state_next = ST_SW_RD;
            REQ_SLOT: state_next = ST_RD;
            default: state_next = ST_DIV;
          endcase
        end
      end
      ST_DIV: if (sts.div_done) state_next = sts.is_oor ? ST_OUT : ST_RD;
      ST_RD: state_next = ST_RDW;
      ST_RDW: state_next = ST_UPD;
      ST_UPD: state_next = ST_OUT;
      ST_SW_RD: state_next = ST_SW_RDW;
      ST_SW_RDW: state_next = ST_SW_WR;
      ST_SW_WR: state_next = sts.sw_last ? ST_OUT : ST_SW_RD;
      ST_OUT: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.clr_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        cmd.div_start = in_fire;
      end
      ST_UPD: begin
        cmd.upd = (req_t'(op) == REQ_ADD);
        cmd.out_load = 1'b1;
      end
      ST_DIV: cmd.out_load = sts.div_done && sts.is_oor;
      ST_SW_RD, ST_SW_RDW: cmd.sw_rd = 1'b1;
      ST_SW_WR: begin
        cmd.sw_wr = 1'b1;
        cmd.sw_inc = 1'b1;
        cmd.out_load = sts.sw_last;
      end
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/wha_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wha_dp import wha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  output sts_t sts,
  input  wire logic [75:0] in_data,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_idx,
  input  wire logic [31:0] cfg_data,
  output logic [31:0] anchor,
  output logic [31:0] bin_size,
  output logic [87:0] out_data
);
  logic [1:0] op;
  logic signed [31:0] wgt;
  logic [SlotW-1:0] slot_r, sw_cnt, clr_cnt;
  logic [SlotW-1:0] lo, hi;
  logic any;

  // Sign-magnitude restoring divider: |num| / den, 36-bit numerator.
  logic [DivW-1:0] rem, quo, den;
  logic [5:0] dcnt;
  logic busy, neg, rnz, done;
  logic signed [DivW-1:0] num;
  logic [DivW:0] trial;
  logic signed [DivW:0] kq;
  logic oor;
  logic [SlotW-1:0] k_slot;

  // Each RAM word holds the occupied flag on top of the height.
  logic [SlotW-1:0] raddr, waddr;
  logic we;
  logic [HeightW:0] wdata, rdata;
  logic signed [HeightW-1:0] newh;
  logic [87:0] out_data_next;

  assign num = ({{4{in_data[33]}}, in_data[33:2]} - {{4{anchor[31]}}, anchor}) * 36'd2
             - {4'd0, bin_size};

  assign trial = {rem[DivW-2:0], quo[DivW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor <= '0;
      bin_size <= 32'h0001_0000;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (dcnt == 6'd1);
      if (cfg_we) begin
        if (cfg_idx == REG_ANCHOR) anchor <= cfg_data;
        else bin_size <= cfg_data;
      end
      if (cmd.div_start && in_data[1:0] != REQ_SHIFT && in_data[1:0] != REQ_SLOT) begin
        busy <= 1'b1;
        dcnt <= 6'(DivW);
        neg <= num[DivW-1];
        quo <= num[DivW-1] ? DivW'(-num) : DivW'(num);
        rem <= '0;
        den <= {3'd0, bin_size, 1'b0};
      end else if (busy) begin
        if (!trial[DivW]) begin
          rem <= {trial[DivW-1:0]};
          quo <= {quo[DivW-2:0], 1'b1};
        end else begin
          rem <= {rem[DivW-2:0], quo[DivW-1]};
          quo <= {quo[DivW-2:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd1) busy <= 1'b0;
      end
    end
  end

  always_comb begin
    rnz = (rem != '0);
    if (neg) kq = -$signed({1'b0, quo});
    else kq = $signed({1'b0, quo}) + (rnz ? 37'sd1 : 37'sd0);
    oor = (bin_size == '0) || (kq < -37'sd512) || (kq > 37'sd511);
    k_slot = SlotW'(kq[SlotW-1:0] + 10'd512);
  end

  assign sts.div_done = done;
  assign sts.is_oor = oor;
  assign sts.sw_last = (sw_cnt == SlotW'(NumBins - 1));
  assign sts.clr_last = (clr_cnt == SlotW'(NumBins - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_data[1:0];
      wgt <= in_data[65:34];
      slot_r <= in_data[75:66];
    end else if (done && !oor) begin
      slot_r <= k_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_cnt <= '0;
      clr_cnt <= '0;
      any <= 1'b0;
      lo <= '0;
      hi <= '0;
    end else begin
      if (cmd.clr_inc) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.sw_inc) sw_cnt <= sw_cnt + 1'b1;
      if (cmd.upd) begin
        any <= 1'b1;
        if (!any || slot_r < lo) lo <= slot_r;
        if (!any || slot_r > hi) hi <= slot_r;
      end
    end
  end

  assign newh = sat_add(rdata[HeightW-1:0], {wgt[31], wgt});
  always_comb begin
    raddr = cmd.sw_rd ? sw_cnt : slot_r;
    we = cmd.clr_wr | cmd.upd | (cmd.sw_wr & rdata[HeightW]);
    waddr = cmd.clr_wr ? clr_cnt : (cmd.sw_wr ? sw_cnt : slot_r);
    if (cmd.clr_wr) wdata = '0;
    else if (cmd.sw_wr) wdata = {1'b1, sat_add(rdata[HeightW-1:0], -{wgt[31], wgt})};
    else wdata = {1'b1, newh};
  end

  wha_ram #(.Width(HeightW + 1), .Depth(NumBins)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    out_data_next = '0;
    if (op != REQ_SHIFT) begin
      if (op != REQ_SLOT && oor && !cmd.upd) out_data_next[59] = 1'b1;
      else begin
        out_data_next[9:0] = slot_r - 10'd512;
        if (op == REQ_ADD) begin
          out_data_next[57:10] = newh;
          out_data_next[58] = 1'b1;
        end else if (rdata[HeightW]) begin
          out_data_next[57:10] = rdata[HeightW-1:0];
          out_data_next[58] = 1'b1;
        end
      end
    end
    if (cmd.upd) begin
      out_data_next[69:60] = (!any || slot_r < lo) ? slot_r - 10'd512 : lo - 10'd512;
      out_data_next[79:70] = (!any || slot_r > hi) ? slot_r - 10'd512 : hi - 10'd512;
      out_data_next[80] = 1'b0;
    end else begin
      out_data_next[69:60] = any ? lo - 10'd512 : 10'd0;
      out_data_next[79:70] = any ? hi - 10'd512 : 10'd0;
      out_data_next[80] = !any;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= out_data_next;
  end
endmodule
`default_nettype wire

// ----- rtl/weighted_histogram_accumulator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Add and read-by-value run the 36-step divider, a RAM read and, for add, an update
// before the result beat; an index outside the store skips the RAM step.
// Read-by-slot skips the divider; subtract-from-all rewrites every occupied bin.
// One item is in flight at a time; the result beat is held until taken, and the next
// input beat is accepted from the cycle after that.
// Reset is synchronous; a clearing pass then zeroes all 1024 bins, blocking input.
module weighted_histogram_accumulator_unit import wha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: req_type[1:0], observable[33:2], weight[65:34], slot[75:66], zero fill
  input  wire logic [79:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: bin_index[9:0], height[57:10], occupied[58], out_of_range[59],
  // lowest_bin[69:60], highest_bin[79:70], store_empty[80], zero fill
  output logic [87:0] m_axis_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  cmd_t cmd;
  sts_t sts;
  logic [31:0] anchor, bin_size;
  logic cfg_we;

  assign pready = 1'b1;
  // Address bit 2 selects between the anchor and the bin size.
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[2] ? bin_size : anchor;

  wha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready), .in_type(s_axis_tdata[1:0]),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  wha_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_data(s_axis_tdata[75:0]),
    .cfg_we(cfg_we), .cfg_idx(paddr[2]), .cfg_data(pwdata),
    .anchor(anchor), .bin_size(bin_size), .out_data(m_axis_tdata)
  );
endmodule
`default_nettype wire
